FILE: hw/rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants of the broadcast child enumerator
// Field widths, register indexes, status codes and the ALU request types.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Field and register widths
  localparam int CODE_W     = 12;
  localparam int NODE_W     = 11;
  localparam int OWN_W      = 10;
  localparam int DEST_W     = 10;
  localparam int FAN_W      = 5;
  localparam int DIMS_W     = 4;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Working width of the shared subtract/compare unit
  localparam int CALC_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FANOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_DIMS  = 3'd4;

  // Topology modes
  localparam logic TOPO_TREE = 1'b0;
  localparam logic TOPO_CUBE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_TARGET  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // Configuration register set
  typedef struct packed {
    logic [NODE_W-1:0] node_count;
    logic [OWN_W-1:0]  own_node;
    logic              topology_mode;
    logic [FAN_W-1:0]  tree_fanout;
    logic [DIMS_W-1:0] cube_dims;
  } cfg_t;

  // Operands into the shared unit
  typedef struct packed {
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
  } alu_req_t;

  // Result of the shared unit
  typedef struct packed {
    logic [CALC_W-1:0] diff;
    logic              ge;
  } alu_rsp_t;

endpackage

FILE: hw/rtl/cbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// cbe_cfg_regs: configuration register file
// Decodes register writes by index and holds the broadcast setup.
// ----------------------------------------------------------------------------
module cbe_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]   wr_data,
  output cbe_pkg::cfg_t                    cfg
);

  // Write one register per request; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count    <= 11'd1;
      cfg.own_node      <= 10'd0;
      cfg.topology_mode <= cbe_pkg::TOPO_TREE;
      cfg.tree_fanout   <= 5'd4;
      cfg.cube_dims     <= 4'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        cbe_pkg::REG_NODE_COUNT: cfg.node_count    <= wr_data[cbe_pkg::NODE_W-1:0];
        cbe_pkg::REG_OWN_NODE:   cfg.own_node      <= wr_data[cbe_pkg::OWN_W-1:0];
        cbe_pkg::REG_TOPOLOGY:   cfg.topology_mode <= wr_data[0];
        cbe_pkg::REG_FANOUT:     cfg.tree_fanout   <= wr_data[cbe_pkg::FAN_W-1:0];
        cbe_pkg::REG_CUBE_DIMS:  cfg.cube_dims     <= wr_data[cbe_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cbe_alu.sv
// ----------------------------------------------------------------------------
// cbe_alu: shared subtract and compare unit
// Gives a - b and the flag a >= b; used for every modulo step and the child bound check.
// ----------------------------------------------------------------------------
module cbe_alu (
  input  cbe_pkg::alu_req_t req,
  output cbe_pkg::alu_rsp_t rsp
);

  logic [cbe_pkg::CALC_W:0] wide;

  // Subtract with one extra bit; the borrow gives the compare
  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = wide[cbe_pkg::CALC_W-1:0];
  assign rsp.ge   = ~wide[cbe_pkg::CALC_W];

endmodule

FILE: hw/rtl/broadcast_child_enumerator_top.sv
// ----------------------------------------------------------------------------
// broadcast_child_enumerator_top: broadcast forwarding list generator
// Sequence: an invalid root goes from S_CHECK straight to S_FINAL; a valid root
// first runs a 10-step restoring modulo of own_node, then S_DIST and S_SETUP,
// then S_SCAN and S_EMIT per child, plus one more S_SCAN per skipped hypercube step.
// Throughput: one request at a time; s_tready returns after the last result.
// Reset: synchronous, active high; only state, m_tvalid and the config registers reset.
// ----------------------------------------------------------------------------
module broadcast_child_enumerator_top #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_FANOUT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // [11:0] root_code
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [9:0] dest_node
  output logic [2:0]                      m_tuser,   // [0] node_level, [2:1] status
  output logic                            m_tlast,   // last_flag
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int W     = cbe_pkg::CALC_W;
  localparam int CNT_W = $clog2(MAX_FANOUT + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_DIST  = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FINAL = 3'd7;

  cbe_pkg::cfg_t     cfg;
  cbe_pkg::alu_req_t alu_req;
  cbe_pkg::alu_rsp_t alu_rsp;

  logic [2:0]                   state;
  logic signed [cbe_pkg::CODE_W-1:0] code;
  logic                         lvl;
  logic [cbe_pkg::NODE_W-1:0]   n_eff;
  logic [cbe_pkg::FAN_W-1:0]    k_eff;
  logic [cbe_pkg::NODE_W-1:0]   root;
  logic [W-1:0]                 rem;
  logic [W-1:0]                 rel_dist;
  logic [W-1:0]                 child;
  logic [W-1:0]                 step;
  logic [cbe_pkg::FAN_W-1:0]    idx;
  logic [CNT_W-1:0]             cnt;
  logic [3:0]                   bit_cnt;
  logic [cbe_pkg::STAT_W-1:0]   fin_status;

  logic [cbe_pkg::DEST_W-1:0]   dest_q;
  logic                         lvl_q;
  logic [cbe_pkg::STAT_W-1:0]   status_q;
  logic                         last_q;

  logic                         slot_free;
  logic                         accept;
  logic [W-1:0]                 step_half;
  logic [W-1:0]                 step_init;
  logic [W-1:0]                 rebased;
  logic                         emit_last;
  logic [cbe_pkg::NODE_W-1:0]   root_in;
  logic                         code_neg;

  cbe_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cbe_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign slot_free = ~m_tvalid | m_tready;

  // Decode the root node from the incoming code
  assign code_neg = s_tdata[cbe_pkg::CODE_W-1];
  assign root_in  = code_neg ? ~s_tdata[cbe_pkg::NODE_W-1:0]
                             : (s_tdata[cbe_pkg::NODE_W-1:0] - 11'd1);

  // Hypercube step helpers
  assign step_half = step >> 1;
  assign step_init = (rel_dist == '0) ? (W'(1) << cfg.cube_dims)
                                      : (rel_dist & (~rel_dist + W'(1)));

  // Route operands into the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_MOD: begin
        alu_req.a = {rem[W-2:0], cfg.own_node[bit_cnt]};
        alu_req.b = W'(n_eff);
      end
      S_DIST: begin
        alu_req.a = rem;
        alu_req.b = W'(root);
      end
      S_SCAN: begin
        alu_req.a = child;
        alu_req.b = W'(n_eff);
      end
      S_EMIT: begin
        alu_req.a = child + W'(root);
        alu_req.b = W'(n_eff);
      end
      default: ;
    endcase
  end

  assign rebased = alu_rsp.ge ? alu_rsp.diff : alu_req.a;

  // Look ahead for the final child of this request
  always_comb begin
    if (cfg.topology_mode == cbe_pkg::TOPO_TREE) begin
      emit_last = (idx == k_eff) || ((child + W'(1)) == W'(n_eff));
    end else begin
      emit_last = (step == W'(1)) || ((32'(cnt) + 1) == MAX_FANOUT);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (code == '0 || root >= n_eff) begin
            state <= S_FINAL;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (bit_cnt == 4'd0) begin
            state <= S_DIST;
          end
        end
        S_DIST: state <= S_SETUP;
        S_SETUP: begin
          if (cfg.topology_mode == cbe_pkg::TOPO_TREE) begin
            state <= (k_eff == '0) ? S_FINAL : S_SCAN;
          end else begin
            state <= ((step_init >> 1) == '0) ? S_FINAL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!alu_rsp.ge) begin
            state <= S_EMIT;
          end else if (cfg.topology_mode == cbe_pkg::TOPO_TREE || step_half == '0) begin
            state <= S_FINAL;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= emit_last ? S_IDLE : S_SCAN;
          end
        end
        S_FINAL: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          code  <= s_tdata[cbe_pkg::CODE_W-1:0];
          lvl   <= code_neg;
          root  <= root_in;
          n_eff <= (32'(cfg.node_count) > MAX_NODES) ? cbe_pkg::NODE_W'(MAX_NODES)
                                                     : cfg.node_count;
          k_eff <= (32'(cfg.tree_fanout) > MAX_FANOUT) ? cbe_pkg::FAN_W'(MAX_FANOUT)
                                                       : cfg.tree_fanout;
        end
      end
      S_CHECK: begin
        fin_status <= cbe_pkg::ST_INVALID;
        rem        <= '0;
        bit_cnt    <= 4'(cbe_pkg::OWN_W - 1);
      end
      S_MOD: begin
        rem     <= rebased;
        bit_cnt <= bit_cnt - 4'd1;
      end
      S_DIST: begin
        rel_dist <= alu_rsp.ge ? alu_rsp.diff : (alu_rsp.diff + W'(n_eff));
      end
      S_SETUP: begin
        fin_status <= cbe_pkg::ST_NONE;
        cnt        <= '0;
        idx        <= cbe_pkg::FAN_W'(1);
        if (cfg.topology_mode == cbe_pkg::TOPO_TREE) begin
          child <= (W'(k_eff) * rel_dist) + W'(1);
        end else begin
          step  <= step_init >> 1;
          child <= rel_dist + (step_init >> 1);
        end
      end
      S_SCAN: begin
        if (alu_rsp.ge && cfg.topology_mode == cbe_pkg::TOPO_CUBE) begin
          step  <= step_half;
          child <= rel_dist + step_half;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cnt <= cnt + CNT_W'(1);
          if (cfg.topology_mode == cbe_pkg::TOPO_TREE) begin
            child <= child + W'(1);
            idx   <= idx + cbe_pkg::FAN_W'(1);
          end else begin
            step  <= step_half;
            child <= rel_dist + step_half;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load a result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (state == S_FINAL && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && slot_free) begin
      dest_q   <= rebased[cbe_pkg::DEST_W-1:0];
      lvl_q    <= lvl;
      status_q <= cbe_pkg::ST_TARGET;
      last_q   <= emit_last;
    end else if (state == S_FINAL && slot_free) begin
      dest_q   <= '0;
      lvl_q    <= lvl;
      status_q <= fin_status;
      last_q   <= 1'b1;
    end
  end

  assign m_tdata = {6'd0, dest_q};
  assign m_tuser = {status_q, lvl_q};
  assign m_tlast = last_q;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for broadcast_child_enumerator_top
// Drives root-code requests in random bursts across many register settings,
// predicts the forwarding list of each request in tree and hypercube mode,
// and checks every result against it while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import cbe_pkg::*;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_FANOUT  = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_PAD   = 4;
  localparam int END_PAD     = 20;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 30;

  // One forwarding result
  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic              level;
    logic [STAT_W-1:0] status;
    logic              last;
  } fwd_t;

  // Forwarding-list predictor and result store
  class forward_list_checker;
    cfg_t regs = '{node_count: 11'd1, own_node: 10'd0, topology_mode: TOPO_TREE,
                   tree_fanout: 5'd4, cube_dims: 4'd0};
    fwd_t pending_fwd[$];
    int   mismatches = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NODE_COUNT: regs.node_count    = data[NODE_W-1:0];
        REG_OWN_NODE:   regs.own_node      = data[OWN_W-1:0];
        REG_TOPOLOGY:   regs.topology_mode = data[0];
        REG_FANOUT:     regs.tree_fanout   = data[FAN_W-1:0];
        REG_CUBE_DIMS:  regs.cube_dims     = data[DIMS_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the children of this node for one accepted request
    function void note_request(logic [CODE_W-1:0] code_bits);
      fwd_t kids[$];
      fwd_t r;
      int   code, n, root, own, rel_dist, fan, child, step;
      logic lvl;
      code = int'($signed(code_bits));
      n = regs.node_count;
      if (n > MAX_NODES) n = MAX_NODES;
      lvl = (code < 0);
      root = (code > 0) ? code - 1 : -code - 1;
      // Zero code or root outside the node range
      if (code == 0 || root >= n) begin
        r = '{dest: '0, level: lvl, status: ST_INVALID, last: 1'b1};
        pending_fwd.push_back(r);
        return;
      end
      own = regs.own_node;
      rel_dist = ((own % n) + n - root) % n;
      if (regs.topology_mode == TOPO_TREE) begin
        fan = regs.tree_fanout;
        if (fan > MAX_FANOUT) fan = MAX_FANOUT;
        for (int i = 1; i <= fan; i++) begin
          child = fan * rel_dist + i;
          if (child > n - 1) break;
          r = '{dest: DEST_W'((child + root) % n), level: lvl, status: ST_TARGET,
                last: 1'b0};
          kids.push_back(r);
        end
      end else begin
        // Start at 2^dims at the root, else at the lowest set bit of the distance
        step = (rel_dist == 0) ? (1 << regs.cube_dims) : (rel_dist & -rel_dist);
        for (step = step >> 1; step > 0; step = step >> 1) begin
          child = rel_dist + step;
          if (child < n && kids.size() < MAX_FANOUT) begin
            r = '{dest: DEST_W'((child + root) % n), level: lvl, status: ST_TARGET,
                  last: 1'b0};
            kids.push_back(r);
          end
        end
      end
      if (kids.size() == 0) begin
        r = '{dest: '0, level: lvl, status: ST_NONE, last: 1'b1};
        kids.push_back(r);
      end else begin
        kids[kids.size() - 1].last = 1'b1;
      end
      foreach (kids[i]) pending_fwd.push_back(kids[i]);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(fwd_t got);
      fwd_t want;
      if (pending_fwd.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result dest=%0d lvl=%0d st=%0d last=%0d",
                   $realtime, got.dest, got.level, got.status, got.last);
        return;
      end
      want = pending_fwd.pop_front();
      if (got.dest !== want.dest || got.level !== want.level ||
          got.status !== want.status || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp dest=%0d lvl=%0d st=%0d last=%0d, got dest=%0d lvl=%0d st=%0d last=%0d",
                   $realtime, want.dest, want.level, want.status, want.last,
                   got.dest, got.level, got.status, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;       // [11:0] root_code
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;            // [9:0] dest_node
  logic [2:0]            m_tuser;            // [0] node_level, [2:1] status
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  forward_list_checker fwd_sb = new;
  int   cycles = 0;
  int   stall_left = 0;
  int   stall_mode = 0;
  logic [7:0] stall_bits = 8'hFF;
  int   cur_nodes = 1;

  broadcast_child_enumerator_top #(
    .MAX_NODES (MAX_NODES),
    .MAX_FANOUT(MAX_FANOUT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the receiver: switch between stall styles every stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
      stall_bits <= 8'($urandom) | 8'h01;
    end else begin
      stall_left <= stall_left - 1;
      stall_bits <= {stall_bits[6:0], stall_bits[7]};
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= stall_bits[7];
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      fwd_sb.check_result('{dest: m_tdata[DEST_W-1:0], level: m_tuser[0],
                            status: m_tuser[2:1], last: m_tlast});
  end

  // Offer one request and hold it until accepted
  task automatic send_request(logic [CODE_W-1:0] code);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(16 - CODE_W){1'b0}}, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fwd_sb.note_request(code);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fwd_sb.set_register(idx, data);
  endtask

  // Drop the request valid and wait until every expected result is in
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (fwd_sb.pending_fwd.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Load a full register set while the block is idle
  task automatic apply_setup(int nodes, int own, logic topo, int fan, int dims);
    wait_drained();
    write_register(REG_NODE_COUNT, CFG_DATA_W'(nodes));
    write_register(REG_OWN_NODE, CFG_DATA_W'(own));
    write_register(REG_TOPOLOGY, CFG_DATA_W'(topo));
    write_register(REG_FANOUT, CFG_DATA_W'(fan));
    write_register(REG_CUBE_DIMS, CFG_DATA_W'(dims));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_nodes = nodes;
  endtask

  // Mostly valid roots of either level, some raw noise
  function automatic logic [CODE_W-1:0] pick_root_code(int nodes);
    int root, lim;
    lim = (nodes > MAX_NODES) ? MAX_NODES : nodes;
    if (lim <= 0 || $urandom_range(0, 99) < 15) return CODE_W'($urandom);
    root = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 1) == 1) return CODE_W'(-(root + 1));
    return CODE_W'(root + 1);
  endfunction

  initial begin
    int nodes, eff, own, fan, dims, left, burst;
    logic topo;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: single node, tree of four
    send_request(12'sd0);
    send_request(12'sd1);
    send_request(-12'sd1);

    // Tree of three over sixteen nodes: extremes, children, leaf
    apply_setup(16, 5, TOPO_TREE, 3, 0);
    send_request(12'sd2047);
    send_request(-12'sd2048);
    send_request(12'sd6);
    send_request(-12'sd3);
    send_request(12'sd16);

    // Full node range with full fanout
    apply_setup(MAX_NODES, 1023, TOPO_TREE, MAX_FANOUT, 0);
    send_request(12'sd1024);
    send_request(-12'sd1);

    // Oversized node count and fanout
    apply_setup(2047, 1000, TOPO_TREE, 31, 0);
    send_request(12'sd1001);
    send_request(-12'sd1025);

    // Zero fanout, own node beyond the node count
    apply_setup(100, 900, TOPO_TREE, 0, 0);
    send_request(12'sd5);

    // Zero node count: every root invalid
    apply_setup(0, 0, TOPO_TREE, 4, 0);
    send_request(12'sd1);
    send_request(-12'sd1);

    // Hypercube: root, inner node, leaf
    apply_setup(16, 0, TOPO_CUBE, 4, 4);
    send_request(12'sd1);
    send_request(-12'sd5);
    send_request(12'sd2);

    // Hypercube with too few dimensions
    apply_setup(13, 0, TOPO_CUBE, 4, 2);
    send_request(12'sd1);
    send_request(-12'sd10);

    // Hypercube with oversized dimensions
    apply_setup(MAX_NODES, 0, TOPO_CUBE, MAX_FANOUT, 15);
    send_request(12'sd1);
    send_request(12'sd2047);

    // Random phases, each with its own register set
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       nodes = 1;
        1:       nodes = 2;
        2:       nodes = MAX_NODES;
        3:       nodes = $urandom_range(MAX_NODES + 1, 2047);
        4, 5, 6: nodes = $urandom_range(3, 64);
        default: nodes = $urandom_range(1, MAX_NODES);
      endcase
      eff = (nodes > MAX_NODES) ? MAX_NODES : nodes;
      own = $urandom_range(0, 1023);
      topo = ph[0];
      case ($urandom_range(0, 7))
        0:       fan = 0;
        1:       fan = 1;
        2:       fan = MAX_FANOUT;
        3:       fan = $urandom_range(MAX_FANOUT + 1, 31);
        default: fan = $urandom_range(2, 8);
      endcase
      dims = ($urandom_range(0, 4) != 0) ? $clog2(eff) : $urandom_range(0, 15);
      apply_setup(nodes, own, topo, fan, dims);

      // Send in bursts with gaps, sometimes pausing until all results are in
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 8);
        if (burst > left) burst = left;
        repeat (burst) send_request(pick_root_code(cur_nodes));
        left -= burst;
        if ($urandom_range(0, 9) == 0) begin
          wait_drained();
        end else begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (END_PAD) @(posedge clk);
    if (fwd_sb.mismatches == 0 && fwd_sb.pending_fwd.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
